// ----- hw/rtl/nucleotide_segment_feature_extractor_macros.svh -----
// ----------------------------------------------------------------------------
// Nucleotide segment feature extractor - assertion macros
// Shared concurrent assertion wrappers, clocked on the rising edge.
// ----------------------------------------------------------------------------
`ifndef NUCLEOTIDE_SEGMENT_FEATURE_EXTRACTOR_MACROS_SVH
`define NUCLEOTIDE_SEGMENT_FEATURE_EXTRACTOR_MACROS_SVH

// Checked outside reset only
`define NSFE_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included
`define NSFE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/nsfe_pkg.sv -----
// ----------------------------------------------------------------------------
// nsfe_pkg
// Constants, types and the character weight map of the feature extractor.
// ----------------------------------------------------------------------------
`default_nettype none

package nsfe_pkg;

   localparam int MAX_SEGMENTS   = 64;
   localparam int LENGTH_BITS    = 16;
   localparam int FRACTION_BITS  = 16;
   localparam int VALUE_BITS     = 41;
   localparam int SEG_BITS       = $clog2(MAX_SEGMENTS + 1);
   localparam int INDEX_BITS     = 6;
   localparam int WEIGHT_BITS    = 17;
   localparam int DIVIDEND_BITS  = VALUE_BITS + FRACTION_BITS;
   localparam int DIVISOR_BITS   = 15 + LENGTH_BITS;
   localparam int DIV_COUNT_BITS = $clog2(DIVIDEND_BITS + 1);
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_AT_WEIGHT     = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CG_WEIGHT     = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_OTHER_WEIGHT  = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SEGMENT_COUNT = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WORD_LENGTH   = 3'd4;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHK_MUL,
      ST_CHK_START,
      ST_CHK_WAIT,
      ST_CHK_CMP,
      ST_ACC,
      ST_FINISH,
      ST_EMIT_PREP,
      ST_EMIT_START,
      ST_EMIT_WAIT,
      ST_EMIT_OUT
   } state_type;

   typedef struct packed {
      logic start;
   } div_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_sts_type;

   function automatic logic signed [WEIGHT_BITS-1:0] weight_of(
      input logic [7:0]         c,
      input logic [14:0]        at_w,
      input logic [14:0]        cg_w,
      input logic signed [15:0] other_w
   );
      logic signed [WEIGHT_BITS-1:0] w;
      case (c)
         "A", "a":           w = $signed({2'b00, at_w});
         "T", "t", "U", "u": w = -$signed({2'b00, at_w});
         "G", "g":           w = $signed({2'b00, cg_w});
         "C", "c":           w = -$signed({2'b00, cg_w});
         "r", "y", "s", "w", "k", "m", "b", "d", "h", "v", "n",
         "R", "Y", "S", "W", "K", "M", "B", "D", "H", "V", "N":
                             w = WEIGHT_BITS'(other_w);
         default:            w = '0;
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/nsfe_div.sv -----
// ----------------------------------------------------------------------------
// nsfe_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module nsfe_div
   import nsfe_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire div_ctl_type              ctl,
   input  wire logic [DIVIDEND_BITS-1:0] dividend,
   input  wire logic [DIVISOR_BITS-1:0]  divisor,
   output div_sts_type                   sts,
   output logic [DIVIDEND_BITS-1:0]      quotient
);

   logic [DIVISOR_BITS:0]     rem_ff, rem_in;
   logic [DIVIDEND_BITS-1:0]  quo_ff, quo_in;
   logic [DIVISOR_BITS-1:0]   dvs_ff, dvs_in;
   logic [DIV_COUNT_BITS-1:0] cnt_ff, cnt_in;
   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [DIVISOR_BITS:0]     trial;

   assign trial = {rem_ff[DIVISOR_BITS-1:0], quo_ff[DIVIDEND_BITS-1]};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctl.start && !busy_ff) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = DIV_COUNT_BITS'(DIVIDEND_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = trial - {1'b0, dvs_ff};
            quo_in = {quo_ff[DIVIDEND_BITS-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[DIVIDEND_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_COUNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/nucleotide_segment_feature_extractor.sv -----
// ----------------------------------------------------------------------------
// nucleotide_segment_feature_extractor
// Per-character weighting and per-segment sums, normalised by a shared divider when a word length is set.
// ----------------------------------------------------------------------------
//  channel   dir   handshake               payload
//  req_      in    req_valid/req_ready     base_char, seq_length
//  rsp_      out   rsp_valid/rsp_ready     feature_index/value, empty_fault, last
//  csr_      in    csr_valid/csr_ready     csr_index, csr_data
//
// A character passes a boundary check (one division of a 57-bit dividend)
// before and one after the accumulate, and one more after each feature;
// a check is only the multiply once all segments are out. A weighted feature
// adds a division for its quotient, a plain or empty one none. The shared serial divider sets rate.
// Reset is synchronous and clears sequence state and registers to defaults.
// A feature waits in its state while the output register is still held.
`default_nettype none
`include "nucleotide_segment_feature_extractor_macros.svh"

module nucleotide_segment_feature_extractor
   import nsfe_pkg::*;
(
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic [7:0]                  req_base_char,
   input  wire logic [LENGTH_BITS-1:0]      req_seq_length,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic [INDEX_BITS-1:0]            rsp_feature_index,
   output logic signed [VALUE_BITS-1:0]     rsp_feature_value,
   output logic                             rsp_empty_fault,
   output logic                             rsp_last_feature,
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic [CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]    csr_data
);

   // configuration
   logic [14:0]        at_ff, cg_ff;
   logic signed [15:0] oth_ff;
   logic [6:0]         nseg_ff;
   logic [7:0]         wlen_ff;

   // sequence state
   state_type                 state_ff, state_in;
   logic [LENGTH_BITS-1:0]    pos_ff, start_ff, lenf_ff;
   logic [SEG_BITS-1:0]       seg_ff;
   logic [7:0]                cyc_ff;
   logic signed [VALUE_BITS-1:0] sum_ff;
   logic [7:0]                ch_ff;
   logic                      post_ff;
   logic [LENGTH_BITS+SEG_BITS-1:0] prod_ff;
   logic [DIVISOR_BITS-1:0]   den_ff;

   logic                      rsp_valid_ff;
   logic [INDEX_BITS-1:0]     rsp_idx_ff;
   logic signed [VALUE_BITS-1:0] rsp_val_ff;
   logic                      rsp_fault_ff, rsp_last_ff;

   logic [SEG_BITS-1:0]       n_eff;
   logic [14:0]               m_eff;
   logic [LENGTH_BITS-1:0]    seglen;
   logic                      seg_done, emit_now, weighted, out_free;
   logic [7:0]                p_pos;
   logic signed [WEIGHT_BITS-1:0] w_cur;
   logic [VALUE_BITS-1:0]     mag;
   logic [DIVIDEND_BITS-1:0]  quo;
   logic signed [VALUE_BITS-1:0] qval;
   logic                      req_fire, emit_fire;

   div_ctl_type div_ctl;
   div_sts_type div_sts;
   logic [DIVIDEND_BITS-1:0] div_dividend;
   logic [DIVISOR_BITS-1:0]  div_divisor;

   always_comb begin
      if (nseg_ff == '0)
         n_eff = SEG_BITS'(1);
      else if (nseg_ff > 7'(MAX_SEGMENTS))
         n_eff = SEG_BITS'(MAX_SEGMENTS);
      else
         n_eff = SEG_BITS'(nseg_ff);
   end

   assign m_eff    = (at_ff > cg_ff) ? at_ff : ((cg_ff == '0) ? 15'd1 : cg_ff);
   assign seglen   = pos_ff - start_ff;
   assign seg_done = (seg_ff >= n_eff);
   assign emit_now = (quo <= DIVIDEND_BITS'(pos_ff));
   assign weighted = (wlen_ff != '0);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign w_cur    = weight_of(ch_ff, at_ff, cg_ff, oth_ff);
   assign mag      = sum_ff[VALUE_BITS-1] ? VALUE_BITS'(-sum_ff) : VALUE_BITS'(sum_ff);

   always_comb begin
      if (pos_ff == start_ff)
         p_pos = '0;
      else if (cyc_ff >= wlen_ff)
         p_pos = 8'd1;
      else
         p_pos = cyc_ff + 8'd1;
   end

   // saturate the Q16 magnitude into the signed result range
   always_comb begin
      if (!sum_ff[VALUE_BITS-1]) begin
         if (quo[DIVIDEND_BITS-1:VALUE_BITS-1] != '0)
            qval = {1'b0, {(VALUE_BITS-1){1'b1}}};
         else
            qval = $signed(quo[VALUE_BITS-1:0]);
      end else begin
         if (quo[DIVIDEND_BITS-1:VALUE_BITS] != '0 ||
             (quo[VALUE_BITS-1] && quo[VALUE_BITS-2:0] != '0))
            qval = {1'b1, {(VALUE_BITS-1){1'b0}}};
         else
            qval = -$signed(quo[VALUE_BITS-1:0]);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:       if (req_valid) state_in = ST_CHK_MUL;
         ST_CHK_MUL:    if (seg_done) state_in = post_ff ? ST_FINISH : ST_ACC;
                        else state_in = ST_CHK_START;
         ST_CHK_START:  state_in = ST_CHK_WAIT;
         ST_CHK_WAIT:   if (div_sts.done) state_in = ST_CHK_CMP;
         ST_CHK_CMP:    if (emit_now) state_in = ST_EMIT_PREP;
                        else state_in = post_ff ? ST_FINISH : ST_ACC;
         ST_ACC:        state_in = ST_CHK_MUL;
         ST_FINISH:     state_in = ST_IDLE;
         ST_EMIT_PREP:  if (weighted && seglen != '0) state_in = ST_EMIT_START;
                        else state_in = ST_EMIT_OUT;
         ST_EMIT_START: state_in = ST_EMIT_WAIT;
         ST_EMIT_WAIT:  if (div_sts.done) state_in = ST_EMIT_OUT;
         ST_EMIT_OUT:   if (out_free) state_in = ST_CHK_MUL;
         default:       state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_ready     = 1'b0;
      div_ctl.start = 1'b0;
      emit_fire     = 1'b0;
      div_dividend  = {mag, {FRACTION_BITS{1'b0}}};
      div_divisor   = den_ff;
      case (state_ff)
         ST_IDLE:       req_ready = 1'b1;
         ST_CHK_START: begin
            div_ctl.start = 1'b1;
            div_dividend  = DIVIDEND_BITS'(prod_ff);
            div_divisor   = DIVISOR_BITS'(n_eff);
         end
         ST_EMIT_START: div_ctl.start = 1'b1;
         ST_EMIT_OUT:   emit_fire = out_free;
         default:       req_ready = 1'b0;
      endcase
   end

   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   nsfe_div u_div (
      .clock    (clock),
      .reset    (reset),
      .ctl      (div_ctl),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .sts      (div_sts),
      .quotient (quo)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         at_ff   <= 15'd1;
         cg_ff   <= 15'd1;
         oth_ff  <= '0;
         nseg_ff <= 7'd1;
         wlen_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_AT_WEIGHT:     at_ff   <= csr_data[14:0];
            CSR_CG_WEIGHT:     cg_ff   <= csr_data[14:0];
            CSR_OTHER_WEIGHT:  oth_ff  <= $signed(csr_data);
            CSR_SEGMENT_COUNT: nseg_ff <= csr_data[6:0];
            CSR_WORD_LENGTH:   wlen_ff <= csr_data[7:0];
            default:           ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         ch_ff   <= req_base_char;
         lenf_ff <= (req_seq_length < pos_ff + 1'b1) ? pos_ff + 1'b1 : req_seq_length;
      end
      if (state_ff == ST_CHK_MUL)
         prod_ff <= (LENGTH_BITS+SEG_BITS)'(lenf_ff * (seg_ff + 1'b1));
      if (state_ff == ST_EMIT_PREP)
         den_ff <= DIVISOR_BITS'(m_eff * seglen);
      if (emit_fire) begin
         rsp_idx_ff   <= seg_ff[INDEX_BITS-1:0];
         rsp_last_ff  <= (seg_ff + 1'b1 == n_eff);
         rsp_fault_ff <= weighted && (seglen == '0);
         if (!weighted)
            rsp_val_ff <= sum_ff;
         else if (seglen == '0)
            rsp_val_ff <= '0;
         else
            rsp_val_ff <= qval;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         start_ff     <= '0;
         seg_ff       <= '0;
         cyc_ff       <= '0;
         sum_ff       <= '0;
         post_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (req_fire)
            post_ff <= 1'b0;
         if (state_ff == ST_ACC) begin
            if (weighted) begin
               sum_ff <= sum_ff + VALUE_BITS'(w_cur * $signed({1'b0, p_pos}));
               cyc_ff <= p_pos;
            end else begin
               sum_ff <= sum_ff + VALUE_BITS'(w_cur);
            end
            pos_ff  <= pos_ff + 1'b1;
            post_ff <= 1'b1;
         end
         if (emit_fire) begin
            seg_ff   <= seg_ff + 1'b1;
            start_ff <= pos_ff;
            sum_ff   <= '0;
            cyc_ff   <= '0;
         end
         if (state_ff == ST_FINISH && (seg_done || pos_ff >= lenf_ff)) begin
            pos_ff   <= '0;
            start_ff <= '0;
            seg_ff   <= '0;
            cyc_ff   <= '0;
            sum_ff   <= '0;
         end
         if (emit_fire)
            rsp_valid_ff <= 1'b1;
         else if (rsp_ready)
            rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_feature_index = rsp_idx_ff;
   assign rsp_feature_value = rsp_val_ff;
   assign rsp_empty_fault   = rsp_fault_ff;
   assign rsp_last_feature  = rsp_last_ff;

   `NSFE_ASSERT(a_idle_div_free, clock, reset, (state_ff == ST_IDLE) |-> !div_sts.busy, "divider busy while idle")
   `NSFE_ASSERT(a_fault_zero, clock, reset, (rsp_valid && rsp_empty_fault) |-> (rsp_feature_value == '0), "faulted feature carries a value")
   `NSFE_ASSERT(a_fault_weighted, clock, reset, $rose(rsp_valid) && rsp_empty_fault |-> weighted, "fault raised in plain mode")
   `NSFE_ASSERT(a_start_idle_div, clock, reset, div_ctl.start |-> !div_sts.busy, "divider started while busy")

endmodule

`default_nettype wire

// ----- test/nsfe_checker.sv -----
// ----------------------------------------------------------------------------
// nsfe_checker
// Watches the request, response and register channels of the feature
// extractor, predicts each segment feature and compares it on arrival.
// ----------------------------------------------------------------------------
module nsfe_checker
   import nsfe_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic [7:0]                    req_base_char,
   input  logic [LENGTH_BITS-1:0]        req_seq_length,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [INDEX_BITS-1:0]         rsp_feature_index,
   input  logic signed [VALUE_BITS-1:0]  rsp_feature_value,
   input  logic                          rsp_empty_fault,
   input  logic                          rsp_last_feature,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [CSR_DATA_BITS-1:0]      csr_data,
   output int                            fail_count,
   output int                            features_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint FEATURE_MAX = 64'sd1099511627775;
   localparam longint FEATURE_MIN = -64'sd1099511627776;

   typedef struct {
      logic [INDEX_BITS-1:0] index;
      logic [VALUE_BITS-1:0] value;
      logic                  fault;
      logic                  last;
   } feature_type;

   feature_type feature_queue[$];

   // register copies
   logic [14:0]        at_w, cg_w;
   logic signed [15:0] other_w;
   logic [6:0]         seg_cnt;
   logic [7:0]         word_len;

   // sequence state
   int     char_pos, seg_no, seg_start, cycle_pos;
   longint seg_sum;

   assign features_pending = feature_queue.size();

   function automatic longint char_weight(logic [7:0] c);
      case (c)
         "A", "a":           return longint'(at_w);
         "T", "t", "U", "u": return -longint'(at_w);
         "G", "g":           return longint'(cg_w);
         "C", "c":           return -longint'(cg_w);
         "r", "y", "s", "w", "k", "m", "b", "d", "h", "v", "n",
         "R", "Y", "S", "W", "K", "M", "B", "D", "H", "V", "N":
            return longint'(other_w);
         default:            return 0;
      endcase
   endfunction

   function automatic int boundary(int seg, int len, int n);
      return int'((longint'(len) * longint'(seg + 1)) / longint'(n));
   endfunction

   // Q16 quotient of sum over max weight times length, toward zero, saturated
   function automatic longint normalised(longint s, int len);
      longint m, d, mag, q, r, res;
      m = (at_w > cg_w) ? longint'(at_w) : longint'(cg_w);
      if (m == 0) m = 1;
      d = m * longint'(len);
      mag = (s < 0) ? -s : s;
      q = mag / d;
      r = mag % d;
      if (q > (FEATURE_MAX >>> FRACTION_BITS) + 1) res = 64'sd1 <<< 41;
      else res = (q <<< FRACTION_BITS) + ((r <<< FRACTION_BITS) / d);
      if (s < 0) return (res > -FEATURE_MIN) ? FEATURE_MIN : -res;
      return (res > FEATURE_MAX) ? FEATURE_MAX : res;
   endfunction

   task automatic close_segment(int n);
      feature_type f;
      int     seg_len;
      longint v;
      seg_len = char_pos - seg_start;
      v = 0;
      f.fault = 1'b0;
      if (word_len == 0) v = seg_sum;
      else if (seg_len == 0) f.fault = 1'b1;
      else v = normalised(seg_sum, seg_len);
      f.index = INDEX_BITS'(seg_no);
      f.value = v[VALUE_BITS-1:0];
      f.last  = (seg_no + 1 == n);
      feature_queue.insert(feature_queue.size(), f);
      seg_no++;
      seg_start = char_pos;
      seg_sum = 0;
      cycle_pos = 0;
   endtask

   task automatic predict_features(logic [7:0] c, logic [LENGTH_BITS-1:0] len_in);
      int     n, len, p;
      longint w;
      n = (seg_cnt == 0) ? 1 : (seg_cnt > MAX_SEGMENTS) ? MAX_SEGMENTS : int'(seg_cnt);
      len = int'(len_in);
      if (len < char_pos + 1) len = char_pos + 1;
      while (seg_no < n && boundary(seg_no, len, n) <= char_pos) close_segment(n);
      w = char_weight(c);
      if (word_len == 0) begin
         seg_sum += w;
      end else begin
         if (char_pos == seg_start) p = 0;
         else if (cycle_pos >= word_len) p = 1;
         else p = cycle_pos + 1;
         seg_sum += w * longint'(p);
         cycle_pos = p;
      end
      char_pos++;
      while (seg_no < n && boundary(seg_no, len, n) <= char_pos) close_segment(n);
      if (seg_no >= n || char_pos >= len) begin
         char_pos = 0;
         seg_no = 0;
         seg_start = 0;
         cycle_pos = 0;
         seg_sum = 0;
      end
   endtask

   always @(posedge clock) begin
      feature_type e;
      if (reset) begin
         at_w = 15'd1;
         cg_w = 15'd1;
         other_w = '0;
         seg_cnt = 7'd1;
         word_len = '0;
         char_pos = 0;
         seg_no = 0;
         seg_start = 0;
         cycle_pos = 0;
         seg_sum = 0;
         fail_count = 0;
         feature_queue.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_AT_WEIGHT:     at_w = csr_data[14:0];
               CSR_CG_WEIGHT:     cg_w = csr_data[14:0];
               CSR_OTHER_WEIGHT:  other_w = csr_data;
               CSR_SEGMENT_COUNT: seg_cnt = csr_data[6:0];
               CSR_WORD_LENGTH:   word_len = csr_data[7:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) predict_features(req_base_char, req_seq_length);
         if (rsp_valid && rsp_ready) begin
            if (feature_queue.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: unexpected feature index %0d value %0d", $realtime,
                           rsp_feature_index, rsp_feature_value);
            end else begin
               e = feature_queue.pop_front();
               if (e.index !== rsp_feature_index || e.value !== rsp_feature_value ||
                   e.fault !== rsp_empty_fault || e.last !== rsp_last_feature) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display({"%0t: feature mismatch exp idx %0d val %0d flt %0b last %0b,",
                               " got idx %0d val %0d flt %0b last %0b"},
                              $realtime, e.index, $signed(e.value), e.fault, e.last,
                              rsp_feature_index, rsp_feature_value, rsp_empty_fault,
                              rsp_last_feature);
               end
            end
         end
      end
   end

endmodule

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Drives characters and register writes into the feature extractor under
// random idling on both channels; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb;
   import nsfe_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SETTLE_CYCLES = 400;
   localparam int HOLD_CYCLES   = 400;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   logic [7:0]                   req_base_char = '0;
   logic [LENGTH_BITS-1:0]       req_seq_length = '0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic [INDEX_BITS-1:0]        rsp_feature_index;
   logic signed [VALUE_BITS-1:0] rsp_feature_value;
   logic                         rsp_empty_fault;
   logic                         rsp_last_feature;
   logic                         csr_valid = 1'b0;
   logic                         csr_ready;
   logic [CSR_INDEX_BITS-1:0]    csr_index = '0;
   logic [CSR_DATA_BITS-1:0]     csr_data = '0;
   int                           fail_count;
   int                           features_pending;

   bit quiet;
   bit hold_off;
   int chars_sent;

   string letters = "ACGTUacgturyswkmbdhvnRYSWKMBDHVN";

   always #2 clock = ~clock;

   nucleotide_segment_feature_extractor i_dut (.*);

   nsfe_checker i_checker (.*);

   function automatic int idle_gap();
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // receiver
   initial begin
      int g;
      forever begin
         @(negedge clock);
         if (reset) begin
            rsp_ready <= 1'b0;
         end else if (hold_off) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_off = 1'b0;
         end else begin
            g = idle_gap();
            rsp_ready <= (g == 0);
            if (g != 0) begin
               repeat (g) @(negedge clock);
               rsp_ready <= 1'b1;
            end
         end
      end
   end

   task automatic send_char(logic [7:0] c, logic [LENGTH_BITS-1:0] len);
      int g;
      g = idle_gap();
      if (g != 0) begin
         req_valid = 1'b0;
         repeat (g) @(negedge clock);
      end
      req_valid = 1'b1;
      req_base_char = c;
      req_seq_length = len;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      chars_sent++;
   endtask

   task automatic write_reg(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] data);
      req_valid = 1'b0;
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic wait_idle();
      req_valid = 1'b0;
      while (features_pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic send_string(string s, logic [LENGTH_BITS-1:0] len);
      foreach (s[i]) send_char(s[i], len);
   endtask

   function automatic logic [7:0] random_char();
      if ($urandom_range(0, 9) < 7) return letters[$urandom_range(0, letters.len() - 1)];
      return 8'($urandom);
   endfunction

   function automatic logic [15:0] pick(int hi);
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 16'(hi);
      if (r == 1) return 16'd1;
      return 16'($urandom_range(0, hi));
   endfunction

   task automatic random_sequence();
      int len, k;
      if ($urandom_range(0, 9) < 8) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
         for (int i = 0; i < len; i++) send_char(random_char(), 16'(len));
      end else begin
         // arbitrary lengths, closed by a too-short length
         k = $urandom_range(1, 4);
         for (int i = 0; i < k; i++) send_char(random_char(), 16'($urandom));
         send_char(random_char(), 16'($urandom_range(0, k)));
      end
   endtask

   initial begin
      int nseq;
      chars_sent = 0;
      quiet = 1'b0;
      hold_off = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // every mapping, plain sum
      write_reg(CSR_AT_WEIGHT, 16'd32767);
      write_reg(CSR_CG_WEIGHT, 16'd1);
      write_reg(CSR_OTHER_WEIGHT, 16'h8000);
      send_string("AaTtUuGgCcNr", 16'd12);
      send_char(8'h00, 16'd2);
      send_char(8'hFF, 16'd2);
      wait_idle();

      // weighted, more segments than characters: empty faults
      write_reg(CSR_AT_WEIGHT, 16'd1);
      write_reg(CSR_CG_WEIGHT, 16'd32767);
      write_reg(CSR_OTHER_WEIGHT, 16'h7FFF);
      write_reg(CSR_SEGMENT_COUNT, 16'd64);
      write_reg(CSR_WORD_LENGTH, 16'd255);
      send_string("ACGT", 16'd4);
      wait_idle();

      // count zero, both weights zero, zero length
      write_reg(CSR_SEGMENT_COUNT, 16'd0);
      write_reg(CSR_WORD_LENGTH, 16'd1);
      write_reg(CSR_AT_WEIGHT, 16'd0);
      write_reg(CSR_CG_WEIGHT, 16'd0);
      send_char("G", 16'd0);
      wait_idle();
      write_reg(CSR_SEGMENT_COUNT, 16'd100);
      write_reg(CSR_WORD_LENGTH, 16'd3);
      send_char("N", 16'hFFFF);
      send_char("A", 16'd0);
      wait_idle();

      // segment count lowered mid-sequence
      write_reg(CSR_SEGMENT_COUNT, 16'd4);
      write_reg(CSR_WORD_LENGTH, 16'd0);
      write_reg(CSR_AT_WEIGHT, 16'd5);
      send_string("AGCT", 16'd8);
      wait_idle();
      write_reg(CSR_SEGMENT_COUNT, 16'd2);
      send_char("A", 16'd8);
      wait_idle();

      // random phases
      for (int ph = 0; chars_sent < 130; ph++) begin
         write_reg(CSR_AT_WEIGHT, pick(32767));
         write_reg(CSR_CG_WEIGHT, pick(32767));
         write_reg(CSR_OTHER_WEIGHT, 16'($urandom));
         write_reg(CSR_SEGMENT_COUNT, ($urandom_range(0, 4) == 0) ? pick(127) : pick(16));
         write_reg(CSR_WORD_LENGTH, ($urandom_range(0, 2) == 0) ? 16'd0 : pick(255));
         quiet = ($urandom_range(0, 3) == 0);
         if (ph == 0) begin
            // receiver blocked while characters keep coming
            write_reg(CSR_SEGMENT_COUNT, 16'd16);
            hold_off = 1'b1;
            for (int i = 0; i < 16; i++) send_char(random_char(), 16'd16);
         end
         nseq = $urandom_range(1, 4);
         for (int s = 0; s < nseq; s++) random_sequence();
         wait_idle();
      end

      if (fail_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   initial begin
      #40ms;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
